[hdl/tut_pkg.sv]
// Shared types, constants and a helper function for the timer UART transceiver.
`timescale 1ns / 1ps

package tut_pkg;

  // Width of the bit timers.
  localparam int TIMER_W = 16;
  // Width of the bit period register.
  localparam int CFG_W = 16;
  // Working width for period arithmetic, with room for the 1.5 bit sum.
  localparam int CALC_W = ((TIMER_W > CFG_W) ? TIMER_W : CFG_W) + 2;

  localparam logic [CFG_W-1:0] BIT_PERIOD_RESET = CFG_W'(104);

  // Register index decoded from the configuration address.
  localparam logic REG_BIT_PERIOD = 1'b0;

  localparam logic [3:0] TX_FRAME_BITS = 4'd11;
  localparam logic [3:0] RX_DATA_BITS  = 4'd8;
  localparam logic [1:0] TX_STOP_BITS  = 2'b11;
  localparam logic       TX_START_BIT  = 1'b0;
  localparam logic [7:0] CHAR_CR       = 8'h0D;

  typedef struct packed {
    logic line;
    logic busy;
  } tx_stat_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       line_end;
  } rx_res_t;

  // Limits a tick count to the range 1 .. largest timer value.
  function automatic logic [TIMER_W-1:0] timer_clamp(input logic [CALC_W-1:0] v);
    logic [CALC_W-1:0] tmax;
    tmax = CALC_W'({TIMER_W{1'b1}});
    if (v > tmax) begin
      return TIMER_W'(tmax);
    end else if (v == '0) begin
      return TIMER_W'(1);
    end else begin
      return TIMER_W'(v);
    end
  endfunction

endpackage

[hdl/tut_tx.sv]
// Transmit framer: shift register and bit timer for one 8N2 frame.
`timescale 1ns / 1ps

module tut_tx (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic                      tx_start_i,
  input  logic [7:0]                tx_byte_i,
  input  logic [tut_pkg::TIMER_W-1:0] period_i,
  output tut_pkg::tx_stat_t         stat_o
);
  import tut_pkg::*;

  logic [10:0]        shift_q, shift_d;
  logic [3:0]         bits_q, bits_d;
  logic [TIMER_W-1:0] timer_q, timer_d;
  logic               active_q, active_d;
  logic               level_q, level_d;

  always_comb begin
    shift_d  = shift_q;
    bits_d   = bits_q;
    timer_d  = timer_q;
    active_d = active_q;
    level_d  = level_q;
    if (!active_q) begin
      if (tx_start_i) begin
        shift_d  = {TX_STOP_BITS, tx_byte_i, TX_START_BIT};
        bits_d   = TX_FRAME_BITS;
        timer_d  = period_i;
        active_d = 1'b1;
      end
    end else if (timer_q <= TIMER_W'(1)) begin
      timer_d = period_i;
      if (bits_q == 4'd0) begin
        active_d = 1'b0;
        bits_d   = TX_FRAME_BITS;
        level_d  = 1'b1;
      end else begin
        level_d = shift_q[0];
        shift_d = {1'b0, shift_q[10:1]};
        bits_d  = bits_q - 4'd1;
      end
    end else begin
      timer_d = timer_q - TIMER_W'(1);
    end
  end

  // The result shows the state after this tick.
  assign stat_o.line = level_d;
  assign stat_o.busy = active_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q  <= '1;
      bits_q   <= TX_FRAME_BITS;
      timer_q  <= '0;
      active_q <= 1'b0;
      level_q  <= 1'b1;
    end else if (step_i) begin
      shift_q  <= shift_d;
      bits_q   <= bits_d;
      timer_q  <= timer_d;
      active_q <= active_d;
      level_q  <= level_d;
    end
  end

  a_idle_line_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (level_q && bits_q == TX_FRAME_BITS))
    else $error("transmitter idle with line low or partial frame count");

  a_timer_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (timer_q != '0 && bits_q <= TX_FRAME_BITS))
    else $error("transmitter active with empty timer or bad bit count");

  a_hold_without_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> ($stable(timer_q) && $stable(bits_q)))
    else $error("transmitter state moved without a tick");

endmodule

[hdl/tut_rx.sv]
// Receive sampler: start edge detect, bit timer and data shift register.
`timescale 1ns / 1ps

module tut_rx (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic                        rx_line_i,
  input  logic [tut_pkg::TIMER_W-1:0] period_i,
  output tut_pkg::rx_res_t            res_o
);
  import tut_pkg::*;

  logic [7:0]         shift_q, shift_d;
  logic [3:0]         bits_q, bits_d;
  logic [TIMER_W-1:0] timer_q, timer_d;
  logic               active_q, active_d;
  logic               prev_q;
  logic [TIMER_W-1:0] first_delay;

  // First sample lands in the middle of data bit 0.
  assign first_delay = timer_clamp(CALC_W'(period_i) + CALC_W'(period_i >> 1));

  always_comb begin
    shift_d        = shift_q;
    bits_d         = bits_q;
    timer_d        = timer_q;
    active_d       = active_q;
    res_o.valid    = 1'b0;
    res_o.data     = 8'd0;
    res_o.line_end = 1'b0;
    if (!active_q) begin
      if (prev_q && !rx_line_i) begin
        active_d = 1'b1;
        bits_d   = RX_DATA_BITS;
        timer_d  = first_delay;
      end
    end else if (timer_q <= TIMER_W'(1)) begin
      timer_d = period_i;
      shift_d = {rx_line_i, shift_q[7:1]};
      bits_d  = bits_q - 4'd1;
      if (bits_q == 4'd1) begin
        res_o.valid    = 1'b1;
        res_o.data     = shift_d;
        res_o.line_end = (shift_d == CHAR_CR);
        active_d       = 1'b0;
        bits_d         = RX_DATA_BITS;
      end
    end else begin
      timer_d = timer_q - TIMER_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q  <= '0;
      bits_q   <= RX_DATA_BITS;
      timer_q  <= '0;
      active_q <= 1'b0;
      prev_q   <= 1'b1;
    end else if (step_i) begin
      shift_q  <= shift_d;
      bits_q   <= bits_d;
      timer_q  <= timer_d;
      active_q <= active_d;
      prev_q   <= rx_line_i;
    end
  end

  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> bits_q == RX_DATA_BITS)
    else $error("receiver idle with partial bit count");

  a_active_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (timer_q != '0 && bits_q != 4'd0 && bits_q <= RX_DATA_BITS))
    else $error("receiver active with bad timer or bit count");

  a_done_ends_rx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.valid) |=> !active_q)
    else $error("receiver still active after reporting a byte");

endmodule

[hdl/timer_uart_transceiver.sv]
// Top level of the timer UART transceiver: stream ports, register port, tick pipeline.
`timescale 1ns / 1ps

// Each stream transaction on the slave side is one clock tick of the UART bit
// timers and produces exactly one transaction on the master side, which shows
// the transmit line, busy, and any byte the receiver completed on that tick.
// The block takes one transaction per cycle at full rate: an input register
// holds the tick, the transmitter and receiver step their state in a single
// pass of logic, and the result register holds the outcome. Throughput is set by
// the result register alone; when the master side stalls, the input register
// absorbs one more tick and then tready drops. The frame is 8N2: a low start
// bit, eight data bits LSB first and two high stop bits, preceded by one idle
// bit time after a start request. The receiver samples 1.5 bit periods after a
// falling edge and then once per bit period; the stop bit is not checked.
// bit_period (byte address 0, reset 104) gives ticks per bit; zero and one
// both mean one tick. Write it only while the block is idle.
module timer_uart_transceiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Tick input.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] tx_start, [8:1] tx_byte, [9] rx_line, [15:10] zero
  input  logic [15:0] s_axis_tdata,
  // Tick result.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] tx_line, [1] tx_busy, [2] rx_valid, [10:3] rx_byte, [11] rx_line_end,
  // [15:12] zero
  output logic [15:0] m_axis_tdata,
  // Register port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tut_pkg::*;

  logic [CFG_W-1:0]   bit_period_q;
  logic [TIMER_W-1:0] period;

  logic               in_vld_q;
  logic               in_start_q;
  logic [7:0]         in_byte_q;
  logic               in_line_q;

  logic               out_vld_q;
  logic [15:0]        out_data_q;

  logic               step;
  tx_stat_t           tx_stat;
  rx_res_t            rx_res;

  // Register port: no wait states, single register at index zero.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BIT_PERIOD) ? 32'(bit_period_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_period_q <= BIT_PERIOD_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_BIT_PERIOD) begin
      bit_period_q <= pwdata[CFG_W-1:0];
    end
  end

  assign period = timer_clamp(CALC_W'(bit_period_q));

  // A tick moves from the input register into the result register whenever the
  // result register is empty or is being drained this cycle.
  assign step          = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_start_q <= s_axis_tdata[0];
      in_byte_q  <= s_axis_tdata[8:1];
      in_line_q  <= s_axis_tdata[9];
    end
  end

  tut_tx u_tx (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .tx_start_i (in_start_q),
    .tx_byte_i  (in_byte_q),
    .period_i   (period),
    .stat_o     (tx_stat)
  );

  tut_rx u_rx (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .rx_line_i (in_line_q),
    .period_i  (period),
    .res_o     (rx_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= {4'd0, rx_res.line_end, rx_res.data, rx_res.valid,
                     tx_stat.busy, tx_stat.line};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  a_step_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> (in_vld_q && (!out_vld_q || m_axis_tready)))
    else $error("tick advanced into an occupied result register");

  a_result_after_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_vld_q)
    else $error("advanced tick produced no result");

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !step) |=> (in_vld_q && $stable(in_byte_q) && $stable(in_start_q)))
    else $error("pending tick lost or changed while stalled");

endmodule
